### rtl/core/xorshift64_star_random_source_unit_defines.svh
// Assertion macros used by the checker file of the random source.
`ifndef XORSHIFT64_STAR_RANDOM_SOURCE_UNIT_DEFINES_SVH
`define XORSHIFT64_STAR_RANDOM_SOURCE_UNIT_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define XS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define XS_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/xs64s_pkg.sv
// Package with the commands, constants and the xorshift function of the random source.
`timescale 1ns / 1ps

package xs64s_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned CMD_W  = 3;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CMD_W-1:0]  cmd_t;

  localparam cmd_t CMD_SEED   = 3'd0;
  localparam cmd_t CMD_WORD64 = 3'd1;
  localparam cmd_t CMD_WORD32 = 3'd2;
  localparam cmd_t CMD_HALF   = 3'd3;
  localparam cmd_t CMD_BYTE   = 3'd4;
  localparam cmd_t CMD_RANGE  = 3'd5;

  localparam word_t GEN_RESET = 64'd4101842887655102017;
  localparam word_t GEN_MULT  = 64'd2685821657736338717;

  localparam int unsigned SHIFT_A   = 21;
  localparam int unsigned SHIFT_B   = 35;
  localparam int unsigned SHIFT_C   = 4;
  localparam int unsigned HALF_BITS = 16;
  localparam int unsigned BYTE_BITS = 8;

  localparam logic [1:0] HALF_REFILL_LEFT = 2'd3;
  localparam logic [2:0] BYTE_REFILL_LEFT = 3'd7;

  function automatic word_t xs_shuffle(input word_t s);
    word_t t;
    t = s ^ (s >> SHIFT_A);
    t = t ^ (t << SHIFT_B);
    t = t ^ (t >> SHIFT_C);
    return t;
  endfunction

endpackage

### rtl/core/xs64s_mul.sv
// Iterative 64-bit low-half multiplier by the generator constant on one 32x32 unit.
`timescale 1ns / 1ps

module xs64s_mul (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  xs64s_pkg::word_t a,
  output logic             done,
  output xs64s_pkg::word_t product
);

  localparam logic [31:0] B_LO = xs64s_pkg::GEN_MULT[31:0];
  localparam logic [31:0] B_HI = xs64s_pkg::GEN_MULT[63:32];

  logic             busy;
  logic [1:0]       step;
  xs64s_pkg::word_t a_q;
  xs64s_pkg::word_t prod;
  xs64s_pkg::word_t acc;
  logic [31:0]      mul_x;
  logic [31:0]      mul_y;

  always_comb begin
    case (step)
      2'd0: begin
        mul_x = a_q[31:0];
        mul_y = B_LO;
      end
      2'd1: begin
        mul_x = a_q[63:32];
        mul_y = B_LO;
      end
      default: begin
        mul_x = a_q[31:0];
        mul_y = B_HI;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
    end
    if (busy) begin
      if (step != 2'd3) begin
        prod <= {32'd0, mul_x} * {32'd0, mul_y};
      end
      case (step)
        2'd1: acc <= prod;
        2'd2, 2'd3: acc[63:32] <= acc[63:32] + prod[31:0];
        default: ;
      endcase
    end
  end

  assign product = acc;

endmodule

### rtl/core/xs64s_div.sv
// Restoring remainder unit that retires one dividend bit per cycle.
`timescale 1ns / 1ps

module xs64s_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  xs64s_pkg::word_t dividend,
  input  xs64s_pkg::word_t divisor,
  output logic             done,
  output xs64s_pkg::word_t remainder
);

  logic             busy;
  logic [5:0]       count;
  xs64s_pkg::word_t dvd;
  xs64s_pkg::word_t dvs;
  xs64s_pkg::word_t rem;
  logic [64:0]      trial;
  logic [64:0]      diff;

  assign trial = {rem, dvd[63]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= 6'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 6'd63;
      end else if (busy) begin
        count <= count - 6'd1;
        if (count == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[62:0], 1'b0};
      if (!diff[64]) begin
        rem <= diff[63:0];
      end else begin
        rem <= trial[63:0];
      end
    end
  end

  assign remainder = rem;

endmodule

### rtl/core/xorshift64_star_random_source_unit.sv
// Top level of the xorshift64* random source with its command sequencer.
`timescale 1ns / 1ps

// One request enters on the s_ stream: s_tuser holds the command, s_tdata the seed and
// the range bounds. Each request gives exactly one transaction on the m_ stream, with
// the value in m_tdata and the zero-span flag in m_tuser.
// The block takes one request at a time. A request drawing a fresh word runs the xorshift
// in the accept cycle and then a 64-bit multiply on one shared 32x32 multiplier in four
// steps. Halfword and byte requests served from a reserve, zero-span ranges and undefined
// commands go from acceptance straight to the finish state. A range request with a nonzero
// span then feeds the product to the one-bit-per-cycle remainder unit. The next request
// is taken as soon as the result is loaded, even while that result still waits in the
// output register. If the receiver stalls, the output register holds its transaction and
// a finished request waits in the sequencer until the register frees. Synchronous reset
// loads the generator with its seed constant, empties both reserves and clears the output
// valid.

module xorshift64_star_random_source_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // seed_value [63:0], range_min [127:64], range_max [191:128]
  input  logic [191:0]  s_tdata,
  // command [2:0]
  input  logic [2:0]    s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  // random_value [63:0]
  output logic [63:0]   m_tdata,
  // span_error [0]
  output logic [0:0]    m_tuser
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_MWAIT = 3'd2;
  localparam logic [2:0] ST_DWAIT = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]          state;
  xs64s_pkg::cmd_t     cmd;
  xs64s_pkg::word_t    gen_state;
  xs64s_pkg::word_t    hw_reserve;
  logic [1:0]          hw_left;
  xs64s_pkg::word_t    by_reserve;
  logic [2:0]          by_left;
  xs64s_pkg::word_t    mul_a;
  xs64s_pkg::word_t    min_q;
  xs64s_pkg::word_t    span;
  xs64s_pkg::word_t    res_value;
  logic                res_err;

  xs64s_pkg::cmd_t     in_cmd;
  xs64s_pkg::word_t    in_seed;
  xs64s_pkg::word_t    in_min;
  xs64s_pkg::word_t    in_max;
  xs64s_pkg::word_t    in_span;
  xs64s_pkg::word_t    shuf_gen;
  logic                accept;
  logic                mul_start;
  logic                mul_done;
  xs64s_pkg::word_t    mul_prod;
  logic                div_start;
  logic                div_done;
  xs64s_pkg::word_t    div_rem;

  assign in_cmd   = s_tuser;
  assign in_seed  = s_tdata[63:0];
  assign in_min   = s_tdata[127:64];
  assign in_max   = s_tdata[191:128];
  assign in_span  = in_max - in_min;
  assign shuf_gen = xs64s_pkg::xs_shuffle(gen_state);

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign mul_start = (state == ST_MUL);
  assign div_start = (state == ST_MWAIT) && mul_done && (cmd == xs64s_pkg::CMD_RANGE);

  xs64s_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .done    (mul_done),
    .product (mul_prod)
  );

  xs64s_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (mul_prod),
    .divisor   (span),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      gen_state  <= xs64s_pkg::GEN_RESET;
      hw_reserve <= '0;
      hw_left    <= 2'd0;
      by_reserve <= '0;
      by_left    <= 3'd0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_FIN)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd       <= in_cmd;
            min_q     <= in_min;
            span      <= in_span;
            res_value <= '0;
            res_err   <= 1'b0;
            mul_a     <= shuf_gen;
            state     <= ST_FIN;
            case (in_cmd)
              xs64s_pkg::CMD_SEED: begin
                mul_a <= xs64s_pkg::xs_shuffle(gen_state ^ in_seed);
                state <= ST_MUL;
              end
              xs64s_pkg::CMD_WORD64, xs64s_pkg::CMD_WORD32: begin
                gen_state <= shuf_gen;
                state     <= ST_MUL;
              end
              xs64s_pkg::CMD_HALF: begin
                if (hw_left != 2'd0) begin
                  hw_left    <= hw_left - 2'd1;
                  hw_reserve <= hw_reserve >> xs64s_pkg::HALF_BITS;
                  res_value  <= {48'd0, hw_reserve[31:16]};
                end else begin
                  gen_state <= shuf_gen;
                  state     <= ST_MUL;
                end
              end
              xs64s_pkg::CMD_BYTE: begin
                if (by_left != 3'd0) begin
                  by_left    <= by_left - 3'd1;
                  by_reserve <= by_reserve >> xs64s_pkg::BYTE_BITS;
                  res_value  <= {56'd0, by_reserve[15:8]};
                end else begin
                  gen_state <= shuf_gen;
                  state     <= ST_MUL;
                end
              end
              xs64s_pkg::CMD_RANGE: begin
                gen_state <= shuf_gen;
                if (in_span == '0) begin
                  res_value <= in_min;
                  res_err   <= 1'b1;
                end else begin
                  state <= ST_MUL;
                end
              end
              default: ;
            endcase
          end
        end
        ST_MUL: begin
          state <= ST_MWAIT;
        end
        ST_MWAIT: begin
          if (mul_done) begin
            state <= ST_FIN;
            case (cmd)
              xs64s_pkg::CMD_SEED: begin
                gen_state <= mul_prod;
                res_value <= '0;
              end
              xs64s_pkg::CMD_WORD64: begin
                res_value <= mul_prod;
              end
              xs64s_pkg::CMD_WORD32: begin
                res_value <= {32'd0, mul_prod[31:0]};
              end
              xs64s_pkg::CMD_HALF: begin
                hw_reserve <= mul_prod;
                hw_left    <= xs64s_pkg::HALF_REFILL_LEFT;
                res_value  <= {48'd0, mul_prod[15:0]};
              end
              xs64s_pkg::CMD_BYTE: begin
                by_reserve <= mul_prod;
                by_left    <= xs64s_pkg::BYTE_REFILL_LEFT;
                res_value  <= {56'd0, mul_prod[7:0]};
              end
              xs64s_pkg::CMD_RANGE: begin
                state <= ST_DWAIT;
              end
              default: ;
            endcase
          end
        end
        ST_DWAIT: begin
          if (div_done) begin
            res_value <= min_q + div_rem;
            state     <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= res_value;
            m_tuser  <= res_err;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/xs64s_checker.sv
// Port-level checker of the random source and its bind to the top level.
`timescale 1ns / 1ps
`include "xorshift64_star_random_source_unit_defines.svh"

module xs64s_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [63:0]  m_tdata,
  input logic [0:0]   m_tuser
);

  logic s_accept;

  assign s_accept = s_tvalid && s_tready;

  // A stalled transaction keeps its payload.
  `XS_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output changed while stalled")

  // The block drops ready in the cycle after it takes a request.
  `XS_ASSERT(a_busy_after_accept, clk, rst, s_accept |=> !s_tready, "ready right after a request")

  // Reset empties the output register.
  `XS_ASSERT_NR(a_reset_clears, clk, rst |=> !m_tvalid, "output valid after reset")

  // A result cannot follow its request in the very next cycle.
  `XS_ASSERT(a_min_latency, clk, rst, s_accept && !m_tvalid |=> !m_tvalid, "result too early")

endmodule

bind xorshift64_star_random_source_unit xs64s_checker u_xs64s_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
